### sv/chu_pkg.sv
// Shared types, filter taps and the round-and-clamp helper for the chroma
// horizontal upsampler. No dependencies.
package chu_pkg;

    localparam int SampleWidth = 8;
    localparam int WinLen      = 7;
    localparam int SumWidth    = 20;

    typedef logic [SampleWidth-1:0]     sample_t;
    typedef logic signed [SumWidth-1:0] sum_t;

    // MPEG-2 cosited interpolation taps
    localparam sum_t M2_TAP_A = 20'sd21;
    localparam sum_t M2_TAP_B = 20'sd52;
    localparam sum_t M2_TAP_C = 20'sd159;

    // MPEG-1 interstitial taps
    localparam sum_t M1_TAP_0 = 20'sd5;
    localparam sum_t M1_TAP_1 = 20'sd21;
    localparam sum_t M1_TAP_2 = 20'sd70;
    localparam sum_t M1_TAP_3 = 20'sd228;
    localparam sum_t M1_TAP_4 = 20'sd37;
    localparam sum_t M1_TAP_5 = 20'sd11;

    localparam sum_t ROUND_BIAS = 20'sd128;

    typedef struct packed {
        logic    advance;
        logic    fill;
        sample_t fill_sample;
    } cell_ctrl_t;

    function automatic sample_t clamp_round(input sum_t sum);
        sum_t    v;
        sample_t r;
        v = sum + ROUND_BIAS;
        if (v[SumWidth-1])
        begin
            r = '0;
        end
        else if (|v[SumWidth-2:16])
        begin
            r = '1;
        end
        else
        begin
            r = v[15:8];
        end
        return r;
    endfunction

endpackage

### sv/chroma_horizontal_upsample.sv
// Top level of the 4:2:2 to 4:4:4 chroma horizontal upsampler.
// Depends on chu_pkg, chu_cell and chu_filter.
//
// Input channel s_axis: one chroma sample per item, tlast on the last sample
// of a line. Output channel m_axis: one even/odd pair per item, tlast on the
// final pair of the line. A line of L samples gives exactly L pairs.
// cfg_wr_en/cfg_wr_data write mpeg2_mode (1 = cosited, 0 = interstitial);
// write it only while the block is idle.
// Throughput: one sample per cycle inside a line while the output is not
// stalled. The pair for sample i is formed once sample i+3 is taken. At a
// line end the window chain shifts three more times with the edge sample
// to flush up to three pairs; s_axis_tready is low while the flush runs.
// A completed pair passes from the pair stage into the output register.
// When m_axis_tready is low the output register holds; the pair stage keeps
// taking samples until it also holds a pair, then s_axis_tready drops.
// Reset clears the window to zero, the line count, all valid flags and sets
// mpeg2_mode to 1.
module chroma_horizontal_upsample (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] chroma_sample
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] even_out, [15:8] odd_out
    output logic        m_axis_tlast    // line_done
);

    logic             mode_reg;
    logic [1:0]       seen_reg,    seen_next;
    logic             flush_reg,   flush_next;
    logic [1:0]       flush_k_reg, flush_k_next;
    logic [1:0]       flush_c_reg, flush_c_next;
    logic             emit_reg,    emit_next;
    logic             done_reg,    done_next;
    logic             out_valid_reg;
    chu_pkg::sample_t out_even_reg;
    chu_pkg::sample_t out_odd_reg;
    logic             out_done_reg;

    logic             out_ready;
    logic             stage_free;
    logic             s_fire;
    logic             flush_step;
    logic [2:0]       flush_sum;
    chu_pkg::cell_ctrl_t cell_ctrl;
    chu_pkg::sample_t win [chu_pkg::WinLen];
    chu_pkg::sample_t shift_src [chu_pkg::WinLen];
    chu_pkg::sample_t even_val;
    chu_pkg::sample_t odd_val;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign stage_free    = !emit_reg || out_ready;
    assign s_axis_tready = !flush_reg && stage_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign flush_step    = flush_reg && stage_free;
    assign flush_sum     = {1'b0, flush_k_reg} + {1'b0, flush_c_reg};

    assign cell_ctrl.advance     = s_fire || flush_step;
    assign cell_ctrl.fill        = s_fire && (seen_reg == 2'd0);
    assign cell_ctrl.fill_sample = s_axis_tdata;

    genvar gi;
    generate
        for (gi = 0; gi < chu_pkg::WinLen; gi++)
        begin : g_cell
            if (gi == chu_pkg::WinLen - 1)
            begin : g_head
                assign shift_src[gi] = flush_reg ? win[gi] : s_axis_tdata;
            end
            else
            begin : g_body
                assign shift_src[gi] = win[gi+1];
            end
            chu_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (cell_ctrl),
                .shift_sample (shift_src[gi]),
                .sample       (win[gi])
            );
        end
    endgenerate

    chu_filter u_filter (
        .win        (win),
        .mpeg2_mode (mode_reg),
        .even_out   (even_val),
        .odd_out    (odd_val)
    );

    always_comb
    begin
        seen_next    = seen_reg;
        flush_next   = flush_reg;
        flush_k_next = flush_k_reg;
        flush_c_next = flush_c_reg;
        emit_next    = emit_reg;
        done_next    = done_reg;
        if (s_fire)
        begin
            emit_next = (seen_reg == 2'd3);
            done_next = 1'b0;
            if (s_axis_tlast)
            begin
                seen_next    = 2'd0;
                flush_next   = 1'b1;
                flush_k_next = 2'd1;
                flush_c_next = seen_reg;
            end
            else if (seen_reg != 2'd3)
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
        else if (flush_step)
        begin
            emit_next    = (flush_sum >= 3'd3);
            done_next    = (flush_k_reg == 2'd3);
            flush_k_next = flush_k_reg + 2'd1;
            if (flush_k_reg == 2'd3)
            begin
                flush_next = 1'b0;
            end
        end
        else if (stage_free)
        begin
            emit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b1;
            seen_reg      <= 2'd0;
            flush_reg     <= 1'b0;
            flush_k_reg   <= 2'd0;
            flush_c_reg   <= 2'd0;
            emit_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            seen_reg    <= seen_next;
            flush_reg   <= flush_next;
            flush_k_reg <= flush_k_next;
            flush_c_reg <= flush_c_next;
            emit_reg    <= emit_next;
            done_reg    <= done_next;
            if (out_ready)
            begin
                out_valid_reg <= emit_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && emit_reg)
        begin
            out_even_reg <= even_val;
            out_odd_reg  <= odd_val;
            out_done_reg <= done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_odd_reg, out_even_reg};
    assign m_axis_tlast  = out_done_reg;

endmodule

### sv/chu_cell.sv
// One stage of the sample window: loads the line's first sample or takes
// its neighbor's sample on each advance. Depends on chu_pkg.
module chu_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  chu_pkg::cell_ctrl_t ctrl,
    input  chu_pkg::sample_t    shift_sample,
    output chu_pkg::sample_t    sample
);

    chu_pkg::sample_t sample_reg;
    chu_pkg::sample_t sample_next;

    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.advance)
        begin
            sample_next = ctrl.fill ? ctrl.fill_sample : shift_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

### sv/chu_filter.sv
// Six-tap even/odd filters over the sample window, rounded and clamped;
// in cosited mode even is the centre sample. Depends on chu_pkg.
module chu_filter (
    input  chu_pkg::sample_t win [chu_pkg::WinLen],
    input  logic             mpeg2_mode,
    output chu_pkg::sample_t even_out,
    output chu_pkg::sample_t odd_out
);

    chu_pkg::sum_t w [chu_pkg::WinLen];
    chu_pkg::sum_t m2_odd;
    chu_pkg::sum_t m1_even;
    chu_pkg::sum_t m1_odd;

    always_comb
    begin
        for (int i = 0; i < chu_pkg::WinLen; i++)
        begin
            w[i] = chu_pkg::sum_t'({12'b0, win[i]});
        end
        m2_odd  = chu_pkg::M2_TAP_A * (w[1] + w[6])
                - chu_pkg::M2_TAP_B * (w[2] + w[5])
                + chu_pkg::M2_TAP_C * (w[3] + w[4]);
        m1_even = chu_pkg::M1_TAP_0 * w[0] - chu_pkg::M1_TAP_1 * w[1]
                + chu_pkg::M1_TAP_2 * w[2] + chu_pkg::M1_TAP_3 * w[3]
                - chu_pkg::M1_TAP_4 * w[4] + chu_pkg::M1_TAP_5 * w[5];
        m1_odd  = chu_pkg::M1_TAP_0 * w[6] - chu_pkg::M1_TAP_1 * w[5]
                + chu_pkg::M1_TAP_2 * w[4] + chu_pkg::M1_TAP_3 * w[3]
                - chu_pkg::M1_TAP_4 * w[2] + chu_pkg::M1_TAP_5 * w[1];
        if (mpeg2_mode)
        begin
            even_out = win[3];
            odd_out  = chu_pkg::clamp_round(m2_odd);
        end
        else
        begin
            even_out = chu_pkg::clamp_round(m1_even);
            odd_out  = chu_pkg::clamp_round(m1_odd);
        end
    end

endmodule
